@@ rtl/core/guillotine_rect_packer_top_assert.svh @@
// Assertion macros for the rectangle packer.
`ifndef GUILLOTINE_RECT_PACKER_TOP_ASSERT_SVH
`define GUILLOTINE_RECT_PACKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define GRP_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("packer assertion failed");
`define GRP_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("packer assertion failed");
`define GRP_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("packer assertion failed");
`else
`define GRP_ASSERT(lbl, cond)
`define GRP_IMPLY(lbl, ante, cons)
`define GRP_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/grp_pkg.sv @@
package grp_pkg;

    localparam int COORD_BITS = 12;

    localparam logic OP_INIT   = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_DROPPED = 2'd1;
    localparam logic [1:0] STAT_NOFIT   = 2'd2;
    localparam logic [1:0] STAT_ZERO    = 2'd3;

    localparam logic REG_ATLAS_WIDTH  = 1'b0;
    localparam logic REG_ATLAS_HEIGHT = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [12:0] req_width;
        logic [12:0] req_height;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] place_x;
        logic [11:0] place_y;
        logic [12:0] placed_width;
        logic [12:0] placed_height;
    } out_item_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

@@ rtl/core/grp_cell.sv @@
module grp_cell #(
    parameter int WIDTH = 50
) (
    input  logic                clk,
    input  grp_pkg::cell_ctrl_t ctrl,
    input  logic [WIDTH-1:0]    shift_in,
    input  logic [WIDTH-1:0]    wr_data,
    output logic [WIDTH-1:0]    entry
);
    import grp_pkg::*;

    logic [WIDTH-1:0] entry_reg;
    logic [WIDTH-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load)
        begin
            entry_next = wr_data;
        end
        else if (ctrl.shift)
        begin
            entry_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ rtl/core/guillotine_rect_packer_top.sv @@
// Insert: after the input transfer the cell ring rotates once through all MAX_FREE_RECTS cells,
// then the best entry is moved and the two remainders are appended before the result;
// when nothing fits the result follows the rotation. Init and zero-size: result in the next cycle.
// One item at a time: the next input transfer is taken the cycle after the result transfer.
// rst_n asynchronous active low: free list empty, atlas 2048 x 2048, no result pending.
`include "guillotine_rect_packer_top_assert.svh"

module guillotine_rect_packer_top #(
    parameter int MAX_FREE_RECTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [12:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  grp_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output grp_pkg::out_item_t out_data
);
    import grp_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int CBW   = COORD_BITS + 1;
    localparam int SW    = (CBW > 13) ? CBW : 13;
    localparam int ENT_W = 2 * CB + 2 * CBW;
    localparam int IDX_W = (MAX_FREE_RECTS > 2) ? $clog2(MAX_FREE_RECTS) : 1;
    localparam int CNT_W = $clog2(MAX_FREE_RECTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MOVE = 3'd2;
    localparam logic [2:0] S_APPA = 3'd3;
    localparam logic [2:0] S_APPB = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [12:0]      atlas_w_reg, atlas_w_next;
    logic [12:0]      atlas_h_reg, atlas_h_next;
    logic [12:0]      rw_reg, rw_next;
    logic [12:0]      rh_reg, rh_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [CBW-1:0]   min_slack_reg, min_slack_next;
    logic [ENT_W-1:0] best_ent_reg, best_ent_next;
    logic [ENT_W-1:0] last_ent_reg, last_ent_next;
    logic [ENT_W-1:0] pa_reg, pa_next;
    logic [ENT_W-1:0] pb_reg, pb_next;
    logic             drop_reg, drop_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [ENT_W-1:0] wr_data;
    logic             shift_all;
    logic [ENT_W-1:0] cell_ent [MAX_FREE_RECTS];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_FREE_RECTS; gi++)
        begin : g_cell
            cell_ctrl_t ctrl;
            assign ctrl.shift = shift_all;
            assign ctrl.load  = wr_en && (wr_idx == IDX_W'(gi));
            grp_cell #(.WIDTH(ENT_W)) u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .shift_in (cell_ent[(gi + 1) % MAX_FREE_RECTS]),
                .wr_data  (wr_data),
                .entry    (cell_ent[gi])
            );
        end
    endgenerate

    always_comb
    begin
        logic [SW-1:0]  hw, hh, rwe, rhe, lw, lh, sc, lim, aw, ah;
        logic           fits;
        logic [CB-1:0]  bx, by;
        logic [SW-1:0]  bw, bh, remw, remh;
        logic [CB-1:0]  xr, yr;
        logic           nonempty;

        state_next      = state_reg;
        atlas_w_next    = atlas_w_reg;
        atlas_h_next    = atlas_h_reg;
        rw_next         = rw_reg;
        rh_next         = rh_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        min_slack_next  = min_slack_reg;
        best_ent_next   = best_ent_reg;
        last_ent_next   = last_ent_reg;
        pa_next         = pa_reg;
        pb_next         = pb_reg;
        drop_next       = drop_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        wr_en           = 1'b0;
        wr_idx          = '0;
        wr_data         = '0;
        shift_all       = 1'b0;

        rwe  = SW'(rw_reg);
        rhe  = SW'(rh_reg);
        hw   = SW'(cell_ent[0][2*CBW-1 -: CBW]);
        hh   = SW'(cell_ent[0][CBW-1:0]);
        fits = (CNT_W'(idx_reg) < count_reg) && (hw >= rwe) && (hh >= rhe);
        lw   = hw - rwe;
        lh   = hh - rhe;
        sc   = (lw < lh) ? lw : lh;
        lim  = SW'(1) << CB;
        aw   = (SW'(atlas_w_reg) > lim) ? lim : SW'(atlas_w_reg);
        ah   = (SW'(atlas_h_reg) > lim) ? lim : SW'(atlas_h_reg);

        bx   = best_ent_reg[ENT_W-1 -: CB];
        by   = best_ent_reg[ENT_W-CB-1 -: CB];
        bw   = SW'(best_ent_reg[2*CBW-1 -: CBW]);
        bh   = SW'(best_ent_reg[CBW-1:0]);
        remw = bw - rwe;
        remh = bh - rhe;
        xr   = CB'(SW'(bx) + rwe);
        yr   = CB'(SW'(by) + rhe);
        nonempty = 1'b0;

        if (cfg_write)
        begin
            if (cfg_index == REG_ATLAS_WIDTH)
            begin
                atlas_w_next = cfg_data;
            end
            else
            begin
                atlas_h_next = cfg_data;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rw_next = in_data.req_width;
                    rh_next = in_data.req_height;
                    out_next = '0;
                    if (in_data.opcode == OP_INIT)
                    begin
                        out_next.status = STAT_OK;
                        if (aw != '0 && ah != '0)
                        begin
                            wr_en   = 1'b1;
                            wr_idx  = '0;
                            wr_data = {CB'(0), CB'(0), CBW'(aw), CBW'(ah)};
                            count_next = CNT_W'(1);
                        end
                        else
                        begin
                            count_next = '0;
                        end
                        out_valid_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else if (in_data.req_width == '0 || in_data.req_height == '0)
                    begin
                        out_next.status = STAT_ZERO;
                        out_valid_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = '0;
                        found_next = 1'b0;
                        drop_next  = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                shift_all = 1'b1;
                if (fits && (!found_reg || CBW'(sc) < min_slack_reg))
                begin
                    found_next      = 1'b1;
                    min_slack_next  = CBW'(sc);
                    best_idx_next   = idx_reg;
                    best_ent_next   = cell_ent[0];
                end
                if (CNT_W'(idx_reg) + CNT_W'(1) == count_reg)
                begin
                    last_ent_next = cell_ent[0];
                end
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(MAX_FREE_RECTS - 1))
                begin
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                if (!found_reg)
                begin
                    out_next.status = STAT_NOFIT;
                    out_valid_next  = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_idx     = best_idx_reg;
                    wr_data    = last_ent_reg;
                    count_next = count_reg - CNT_W'(1);
                    if (remw > remh)
                    begin
                        pa_next = {xr, by, CBW'(remw), CBW'(bh)};
                        pb_next = {bx, yr, CBW'(rwe), CBW'(remh)};
                    end
                    else
                    begin
                        pa_next = {bx, yr, CBW'(bw), CBW'(remh)};
                        pb_next = {xr, by, CBW'(remw), CBW'(rhe)};
                    end
                    state_next = S_APPA;
                end
            end
            S_APPA, S_APPB:
            begin
                wr_data  = (state_reg == S_APPA) ? pa_reg : pb_reg;
                nonempty = (wr_data[2*CBW-1 -: CBW] != '0) && (wr_data[CBW-1:0] != '0);
                if (nonempty)
                begin
                    if (count_reg < CNT_W'(MAX_FREE_RECTS))
                    begin
                        wr_en      = 1'b1;
                        wr_idx     = count_reg[IDX_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
                if (state_reg == S_APPA)
                begin
                    state_next = S_APPB;
                end
                else
                begin
                    out_next.status = (drop_next) ? STAT_DROPPED : STAT_OK;
                    out_next.place_x       = 12'(SW'(bx));
                    out_next.place_y       = 12'(SW'(by));
                    out_next.placed_width  = rw_reg;
                    out_next.placed_height = rh_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            atlas_w_reg   <= 13'd2048;
            atlas_h_reg   <= 13'd2048;
            count_reg     <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            atlas_w_reg   <= atlas_w_next;
            atlas_h_reg   <= atlas_h_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rw_reg         <= rw_next;
        rh_reg         <= rh_next;
        best_idx_reg   <= best_idx_next;
        min_slack_reg  <= min_slack_next;
        best_ent_reg   <= best_ent_next;
        last_ent_reg   <= last_ent_next;
        pa_reg         <= pa_next;
        pb_reg         <= pb_next;
        out_reg        <= out_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `GRP_ASSERT(a_count_bound, count_reg <= CNT_W'(MAX_FREE_RECTS))
    `GRP_IMPLY(a_valid_in_done, out_valid_reg, state_reg == S_DONE)
    `GRP_NEXT(a_scan_end, state_reg == S_SCAN && idx_reg == IDX_W'(MAX_FREE_RECTS - 1), state_reg == S_MOVE)
    `GRP_IMPLY(a_best_valid, (state_reg == S_MOVE) && found_reg, CNT_W'(best_idx_reg) < count_reg)

endmodule
